/* src/dlmsrd_pkg.sv */
package dlmsrd_pkg;

    // A-XDR type tags
    localparam logic [7:0] TY_STRUCT = 8'h02;
    localparam logic [7:0] TY_OCTETS = 8'h09;
    localparam logic [7:0] TY_U32    = 8'h06;
    localparam logic [7:0] TY_I16    = 8'h10;
    localparam logic [7:0] TY_U16    = 8'h12;
    localparam logic [7:0] TY_I8     = 8'h0f;
    localparam logic [7:0] TY_ENUM   = 8'h16;

    // Frame status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_BADTAG   = 3'd2;
    localparam logic [2:0] ST_BADSTART = 3'd3;
    localparam logic [2:0] ST_UNKNOWN  = 3'd4;
    localparam logic [2:0] ST_TRUNC    = 3'd5;

    // Result kinds
    localparam logic RK_RECORD = 1'b0;
    localparam logic RK_STATUS = 1'b1;

    // Register indexes
    localparam logic REG_APDU_TAG  = 1'b0;
    localparam logic REG_THRESHOLD = 1'b1;

    localparam logic [7:0] APDU_TAG_RST  = 8'h0f;
    localparam logic [7:0] THRESHOLD_RST = 8'd10;

    localparam int MIN_FRAME    = 9;
    localparam int REGION_MIN   = 4;
    localparam int EXT_HDR_POS  = 5;
    localparam int HDR_SIZE_LEN = 2;

    localparam int OFFSET_W = 11;
    localparam int LENGTH_W = 12;
    localparam int OUT_TDATA_W = 56;

    typedef enum logic [6:0] {
        PH_HEADER = 7'b0000001,
        PH_TAG    = 7'b0000010,
        PH_COUNT  = 7'b0000100,
        PH_STRLEN = 7'b0001000,
        PH_SKIP   = 7'b0010000,
        PH_STRAY  = 7'b0100000,
        PH_ERROR  = 7'b1000000
    } phase_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PROC  = 5'b00010,
        S_CLOSE = 5'b00100,
        S_REC   = 5'b01000,
        S_STAT  = 5'b10000
    } seq_t;

endpackage

/* src/dlms_cosem_record_delimiter.sv */
// A payload byte that closes no element is accepted, then parsed.
// Closing an element walks the nesting stack through the decrement unit, one
// open struct per cycle. Each result then moves into the output register when free.
// Reset (aresetn low, synchronous) clears sequencer and parse state, sets
// apdu_tag to 0x0f and report_threshold to 10; the element count stack is not cleared.
module dlms_cosem_record_delimiter #(
    parameter int MAX_FRAME  = 2048,
    parameter int NEST_DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [10:0] record_offset, [22:11] record_length, [23] reportable,
    // [26:24] frame_status, [38:27] decoded_length, [50:39] stray_count, [55:51] zero
    output logic [dlmsrd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic        m_axis_tuser,   // result_kind
    output logic        m_axis_tlast    // last
);

    localparam int IDX_W = $clog2(MAX_FRAME + 1);
    localparam int NL_W  = $clog2(NEST_DEPTH + 1);
    localparam int SP_W  = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int CMP_W = (IDX_W > 8) ? IDX_W : 8;

    // configuration
    logic [7:0] apdu_tag_reg, threshold_reg;
    logic       cfg_wr;

    // sequencer and parse state
    dlmsrd_pkg::seq_t   state_reg, state_next;
    dlmsrd_pkg::phase_t phase_reg, phase_next;
    logic [IDX_W-1:0]   byte_index_reg, byte_index_next;
    logic [IDX_W-1:0]   record_start_reg, record_start_next;
    logic [IDX_W-1:0]   region_bytes_reg, region_bytes_next;
    logic [8:0]         hskip_reg, hskip_next;
    logic [8:0]         prim_left_reg, prim_left_next;
    logic [NL_W-1:0]    nest_level_reg, nest_level_next;
    logic [2:0]         error_code_reg, error_code_next;
    logic [7:0]         byte_reg;
    logic               fin_reg;

    // element count stack
    logic [7:0]      stack_mem [NEST_DEPTH];
    logic            stk_we;
    logic [SP_W-1:0] stk_addr;
    logic [7:0]      stk_wdata;
    logic [SP_W-1:0] top_idx;
    logic [7:0]      top_dec;

    // output register
    logic                              m_valid_reg;
    logic [dlmsrd_pkg::OUT_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                              m_kind_reg, m_kind_next;
    logic                              m_last_reg, m_last_next;
    logic                              out_free, out_load;

    // derived values
    logic [IDX_W-1:0] p;
    logic             bad_start;
    logic [CMP_W-1:0] rec_len;
    logic [2:0]       status;
    logic [IDX_W-1:0] dec_len, stray;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == dlmsrd_pkg::REG_THRESHOLD) ? {24'd0, threshold_reg}
                                                            : {24'd0, apdu_tag_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            apdu_tag_reg  <= dlmsrd_pkg::APDU_TAG_RST;
            threshold_reg <= dlmsrd_pkg::THRESHOLD_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == dlmsrd_pkg::REG_THRESHOLD) begin
                threshold_reg <= pwdata[7:0];
            end else begin
                apdu_tag_reg <= pwdata[7:0];
            end
        end
    end

    assign s_axis_tready = (state_reg == dlmsrd_pkg::S_IDLE);

    assign p         = byte_index_reg;
    assign top_idx   = SP_W'(nest_level_reg - NL_W'(1));
    assign top_dec   = stack_mem[top_idx] - 8'd1;
    assign bad_start = (region_bytes_reg == IDX_W'(0) && byte_reg != dlmsrd_pkg::TY_STRUCT) ||
                       (region_bytes_reg == IDX_W'(2) && byte_reg != dlmsrd_pkg::TY_OCTETS) ||
                       (region_bytes_reg == IDX_W'(3) && byte_reg != dlmsrd_pkg::TY_U32);

    assign rec_len = CMP_W'(byte_index_reg) - CMP_W'(record_start_reg);
    assign dec_len = record_start_reg - (byte_index_reg - region_bytes_reg);
    assign stray   = region_bytes_reg - dec_len;

    always_comb begin
        if (32'(byte_index_reg) < dlmsrd_pkg::MIN_FRAME) begin
            status = dlmsrd_pkg::ST_SHORT;
        end else if (error_code_reg == dlmsrd_pkg::ST_BADTAG) begin
            status = dlmsrd_pkg::ST_BADTAG;
        end else if (phase_reg == dlmsrd_pkg::PH_HEADER ||
                     32'(region_bytes_reg) < dlmsrd_pkg::REGION_MIN) begin
            status = dlmsrd_pkg::ST_SHORT;
        end else if (error_code_reg != dlmsrd_pkg::ST_OK) begin
            status = error_code_reg;
        end else if (nest_level_reg != NL_W'(0) || phase_reg == dlmsrd_pkg::PH_COUNT ||
                     phase_reg == dlmsrd_pkg::PH_STRLEN || phase_reg == dlmsrd_pkg::PH_SKIP) begin
            status = dlmsrd_pkg::ST_TRUNC;
        end else begin
            status = dlmsrd_pkg::ST_OK;
        end
    end

    assign out_free = ~m_valid_reg | m_axis_tready;

    always_comb begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        byte_index_next   = byte_index_reg;
        record_start_next = record_start_reg;
        region_bytes_next = region_bytes_reg;
        hskip_next        = hskip_reg;
        prim_left_next    = prim_left_reg;
        nest_level_next   = nest_level_reg;
        error_code_next   = error_code_reg;
        stk_we            = 1'b0;
        stk_addr          = top_idx;
        stk_wdata         = top_dec;
        out_load          = 1'b0;
        m_data_next       = '0;
        m_kind_next       = dlmsrd_pkg::RK_RECORD;
        m_last_next       = 1'b1;

        unique case (state_reg)
            dlmsrd_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = dlmsrd_pkg::S_PROC;
                end
            end

            dlmsrd_pkg::S_PROC: begin
                state_next = fin_reg ? dlmsrd_pkg::S_STAT : dlmsrd_pkg::S_IDLE;
                if (byte_index_reg < IDX_W'(MAX_FRAME)) begin
                    byte_index_next = byte_index_reg + IDX_W'(1);
                    if (phase_reg == dlmsrd_pkg::PH_HEADER) begin
                        if (p == IDX_W'(0)) begin
                            if (byte_reg != apdu_tag_reg) begin
                                error_code_next = dlmsrd_pkg::ST_BADTAG;
                                phase_next      = dlmsrd_pkg::PH_ERROR;
                            end
                        end else if (p == IDX_W'(dlmsrd_pkg::EXT_HDR_POS)) begin
                            hskip_next = {1'b0, byte_reg} + 9'(dlmsrd_pkg::HDR_SIZE_LEN);
                        end else if (p > IDX_W'(dlmsrd_pkg::EXT_HDR_POS)) begin
                            hskip_next = hskip_reg - 9'd1;
                            if (hskip_reg == 9'd1) begin
                                phase_next        = dlmsrd_pkg::PH_TAG;
                                record_start_next = p + IDX_W'(1);
                            end
                        end
                    end else if (error_code_reg != dlmsrd_pkg::ST_BADTAG) begin
                        region_bytes_next = region_bytes_reg + IDX_W'(1);
                        if (error_code_reg == dlmsrd_pkg::ST_OK && bad_start) begin
                            error_code_next = dlmsrd_pkg::ST_BADSTART;
                            phase_next      = dlmsrd_pkg::PH_ERROR;
                        end else begin
                            case (phase_reg)
                                dlmsrd_pkg::PH_TAG: begin
                                    if (nest_level_reg == NL_W'(0)) begin
                                        phase_next = (byte_reg == dlmsrd_pkg::TY_STRUCT) ?
                                                     dlmsrd_pkg::PH_COUNT : dlmsrd_pkg::PH_STRAY;
                                    end else begin
                                        case (byte_reg)
                                            dlmsrd_pkg::TY_STRUCT: phase_next = dlmsrd_pkg::PH_COUNT;
                                            dlmsrd_pkg::TY_OCTETS: phase_next = dlmsrd_pkg::PH_STRLEN;
                                            dlmsrd_pkg::TY_U32: begin
                                                prim_left_next = 9'd4;
                                                phase_next     = dlmsrd_pkg::PH_SKIP;
                                            end
                                            dlmsrd_pkg::TY_I16, dlmsrd_pkg::TY_U16: begin
                                                prim_left_next = 9'd2;
                                                phase_next     = dlmsrd_pkg::PH_SKIP;
                                            end
                                            dlmsrd_pkg::TY_I8, dlmsrd_pkg::TY_ENUM: begin
                                                prim_left_next = 9'd1;
                                                phase_next     = dlmsrd_pkg::PH_SKIP;
                                            end
                                            default: begin
                                                error_code_next = dlmsrd_pkg::ST_UNKNOWN;
                                                phase_next      = dlmsrd_pkg::PH_ERROR;
                                            end
                                        endcase
                                    end
                                end
                                dlmsrd_pkg::PH_COUNT: begin
                                    if (byte_reg == 8'd0) begin
                                        phase_next = dlmsrd_pkg::PH_TAG;
                                        state_next = dlmsrd_pkg::S_CLOSE;
                                    end else if (nest_level_reg >= NL_W'(NEST_DEPTH)) begin
                                        error_code_next = dlmsrd_pkg::ST_UNKNOWN;
                                        phase_next      = dlmsrd_pkg::PH_ERROR;
                                    end else begin
                                        // push the element count
                                        stk_we          = 1'b1;
                                        stk_addr        = SP_W'(nest_level_reg);
                                        stk_wdata       = byte_reg;
                                        nest_level_next = nest_level_reg + NL_W'(1);
                                        phase_next      = dlmsrd_pkg::PH_TAG;
                                    end
                                end
                                dlmsrd_pkg::PH_STRLEN: begin
                                    if (byte_reg == 8'd0) begin
                                        phase_next = dlmsrd_pkg::PH_TAG;
                                        state_next = dlmsrd_pkg::S_CLOSE;
                                    end else begin
                                        prim_left_next = {1'b0, byte_reg};
                                        phase_next     = dlmsrd_pkg::PH_SKIP;
                                    end
                                end
                                dlmsrd_pkg::PH_SKIP: begin
                                    prim_left_next = prim_left_reg - 9'd1;
                                    if (prim_left_reg == 9'd1) begin
                                        phase_next = dlmsrd_pkg::PH_TAG;
                                        state_next = dlmsrd_pkg::S_CLOSE;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                end
            end

            // pop finished structs, one level per cycle
            dlmsrd_pkg::S_CLOSE: begin
                if (nest_level_reg == NL_W'(0)) begin
                    state_next = dlmsrd_pkg::S_REC;
                end else begin
                    stk_we = 1'b1;
                    if (top_dec != 8'd0) begin
                        state_next = fin_reg ? dlmsrd_pkg::S_STAT : dlmsrd_pkg::S_IDLE;
                    end else begin
                        nest_level_next = nest_level_reg - NL_W'(1);
                    end
                end
            end

            dlmsrd_pkg::S_REC: begin
                if (out_free) begin
                    out_load          = 1'b1;
                    m_kind_next       = dlmsrd_pkg::RK_RECORD;
                    m_last_next       = ~fin_reg;
                    m_data_next[10:0] = dlmsrd_pkg::OFFSET_W'(record_start_reg);
                    m_data_next[22:11] = dlmsrd_pkg::LENGTH_W'(rec_len);
                    m_data_next[23]   = (rec_len > CMP_W'(threshold_reg));
                    record_start_next = byte_index_reg;
                    state_next        = fin_reg ? dlmsrd_pkg::S_STAT : dlmsrd_pkg::S_IDLE;
                end
            end

            dlmsrd_pkg::S_STAT: begin
                if (out_free) begin
                    out_load           = 1'b1;
                    m_kind_next        = dlmsrd_pkg::RK_STATUS;
                    m_last_next        = 1'b1;
                    m_data_next[26:24] = status;
                    if (status == dlmsrd_pkg::ST_OK) begin
                        m_data_next[38:27] = dlmsrd_pkg::LENGTH_W'(dec_len);
                        m_data_next[50:39] = dlmsrd_pkg::LENGTH_W'(stray);
                    end
                    // clear for the next frame
                    byte_index_next   = '0;
                    phase_next        = dlmsrd_pkg::PH_HEADER;
                    hskip_next        = '0;
                    nest_level_next   = '0;
                    prim_left_next    = '0;
                    record_start_next = '0;
                    region_bytes_next = '0;
                    error_code_next   = dlmsrd_pkg::ST_OK;
                    state_next        = dlmsrd_pkg::S_IDLE;
                end
            end

            default: state_next = dlmsrd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= dlmsrd_pkg::S_IDLE;
            phase_reg        <= dlmsrd_pkg::PH_HEADER;
            byte_index_reg   <= '0;
            record_start_reg <= '0;
            region_bytes_reg <= '0;
            hskip_reg        <= '0;
            prim_left_reg    <= '0;
            nest_level_reg   <= '0;
            error_code_reg   <= dlmsrd_pkg::ST_OK;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            byte_index_reg   <= byte_index_next;
            record_start_reg <= record_start_next;
            region_bytes_reg <= region_bytes_next;
            hskip_reg        <= hskip_next;
            prim_left_reg    <= prim_left_next;
            nest_level_reg   <= nest_level_next;
            error_code_reg   <= error_code_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            byte_reg <= s_axis_tdata;
            fin_reg  <= s_axis_tlast;
        end
        if (out_load) begin
            m_data_reg <= m_data_next;
            m_kind_reg <= m_kind_next;
            m_last_reg <= m_last_next;
        end
        if (stk_we) begin
            stack_mem[stk_addr] <= stk_wdata;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tlast  = m_last_reg;

    a_nest_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nest_level_reg <= NL_W'(NEST_DEPTH))
        else $error("nesting level beyond stack depth");

    a_header_no_region: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == dlmsrd_pkg::PH_HEADER |-> region_bytes_reg == '0)
        else $error("region bytes counted during header");

    a_skip_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != dlmsrd_pkg::PH_HEADER |-> hskip_reg == '0)
        else $error("header skip left over after header");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_kind_reg == dlmsrd_pkg::RK_STATUS |-> m_last_reg)
        else $error("status result not marked last");

    a_close_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == dlmsrd_pkg::S_CLOSE |-> !s_axis_tready && phase_reg == dlmsrd_pkg::PH_TAG)
        else $error("close walk outside tag phase");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import dlmsrd_pkg::*;

    localparam int FRAME_CAP    = 2048;
    localparam int STACK_DEPTH  = 8;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        logic        kind;
        logic [10:0] offset;
        logic [11:0] length;
        logic        reportable;
        logic [2:0]  status;
        logic [11:0] decoded;
        logic [11:0] stray;
        logic        last;
    } result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    // predictor copy of the registers and the frame parser
    logic [7:0]  cfg_tag = APDU_TAG_RST;
    logic [7:0]  cfg_threshold = THRESHOLD_RST;
    int unsigned fr_pos;
    int unsigned fr_hdr_left;
    int unsigned fr_level;
    int unsigned fr_prim_left;
    int unsigned fr_rec_start;
    int unsigned fr_region;
    logic [7:0]  fr_counts [STACK_DEPTH];
    logic [2:0]  fr_err;
    phase_t      fr_phase;

    result_t     expected_results[$];
    logic [7:0]  frame_buf[$];
    int          errors = 0;
    int          cycle_count = 0;
    bit          idle_on = 1'b1;
    bit          hold_off_req = 1'b0;

    dlms_cosem_record_delimiter DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic logic [7:0] rand_byte();
        int unsigned v;
        v = $urandom;
        return v[7:0];
    endfunction

    // ---------------- frame parser prediction ----------------

    function automatic void clear_frame();
        fr_pos = 0;
        fr_phase = PH_HEADER;
        fr_hdr_left = 0;
        fr_level = 0;
        fr_prim_left = 0;
        fr_rec_start = 0;
        fr_region = 0;
        fr_err = ST_OK;
        foreach (fr_counts[i]) fr_counts[i] = '0;
    endfunction

    function automatic void set_error(logic [2:0] code);
        fr_err = code;
        fr_phase = PH_ERROR;
    endfunction

    function automatic void add_result(logic kind, int unsigned off, int unsigned len,
                                       logic rep, logic [2:0] st, int unsigned dec,
                                       int unsigned stray, logic lst);
        result_t r;
        r.kind = kind;
        r.offset = off[10:0];
        r.length = len[11:0];
        r.reportable = rep;
        r.status = st;
        r.decoded = dec[11:0];
        r.stray = stray[11:0];
        r.last = lst;
        expected_results.push_back(r);
    endfunction

    // An element has ended: count down the open structs; 1 when the record is done.
    function automatic bit close_element();
        fr_phase = PH_TAG;
        while (fr_level != 0) begin
            fr_counts[fr_level-1] = fr_counts[fr_level-1] - 8'd1;
            if (fr_counts[fr_level-1] != 8'd0) return 1'b0;
            fr_level--;
        end
        return 1'b1;
    endfunction

    function automatic bit parse_region_byte(logic [7:0] b);
        int unsigned r;
        r = fr_region;
        fr_region++;
        if (fr_err == ST_OK && ((r == 0 && b != TY_STRUCT) || (r == 2 && b != TY_OCTETS) ||
                                (r == 3 && b != TY_U32))) begin
            set_error(ST_BADSTART);
            return 1'b0;
        end
        case (fr_phase)
            PH_TAG: begin
                if (fr_level == 0) begin
                    fr_phase = (b == TY_STRUCT) ? PH_COUNT : PH_STRAY;
                    return 1'b0;
                end
                case (b)
                    TY_STRUCT: fr_phase = PH_COUNT;
                    TY_OCTETS: fr_phase = PH_STRLEN;
                    TY_U32: begin
                        fr_prim_left = 4;
                        fr_phase = PH_SKIP;
                    end
                    TY_I16, TY_U16: begin
                        fr_prim_left = 2;
                        fr_phase = PH_SKIP;
                    end
                    TY_I8, TY_ENUM: begin
                        fr_prim_left = 1;
                        fr_phase = PH_SKIP;
                    end
                    default: set_error(ST_UNKNOWN);
                endcase
                return 1'b0;
            end
            PH_COUNT: begin
                if (b == 8'd0) return close_element();
                if (fr_level >= STACK_DEPTH) begin
                    set_error(ST_UNKNOWN);
                    return 1'b0;
                end
                fr_counts[fr_level] = b;
                fr_level++;
                fr_phase = PH_TAG;
                return 1'b0;
            end
            PH_STRLEN: begin
                if (b == 8'd0) return close_element();
                fr_prim_left = b;
                fr_phase = PH_SKIP;
                return 1'b0;
            end
            PH_SKIP: begin
                fr_prim_left--;
                if (fr_prim_left == 0) return close_element();
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic fin);
        int unsigned p;
        int unsigned rlen;
        int unsigned dec;
        int unsigned stray;
        logic [2:0]  st;
        if (fr_pos < FRAME_CAP) begin
            p = fr_pos;
            fr_pos++;
            if (fr_phase == PH_HEADER) begin
                if (p == 0) begin
                    if (b != cfg_tag) set_error(ST_BADTAG);
                end else if (p == EXT_HDR_POS) begin
                    fr_hdr_left = b + HDR_SIZE_LEN;
                end else if (p > EXT_HDR_POS) begin
                    fr_hdr_left--;
                    if (fr_hdr_left == 0) begin
                        fr_phase = PH_TAG;
                        fr_rec_start = p + 1;
                    end
                end
            end else if (fr_err != ST_BADTAG) begin
                if (parse_region_byte(b)) begin
                    rlen = p + 1 - fr_rec_start;
                    add_result(RK_RECORD, fr_rec_start, rlen, rlen > cfg_threshold,
                               ST_OK, 0, 0, !fin);
                    fr_rec_start = p + 1;
                end
            end
        end
        if (fin) begin
            dec = 0;
            stray = 0;
            if (fr_pos < MIN_FRAME) st = ST_SHORT;
            else if (fr_err == ST_BADTAG) st = ST_BADTAG;
            else if (fr_phase == PH_HEADER) st = ST_SHORT;
            else if (fr_region < REGION_MIN) st = ST_SHORT;
            else if (fr_err != ST_OK) st = fr_err;
            else if (fr_level != 0 || fr_phase == PH_COUNT || fr_phase == PH_STRLEN ||
                     fr_phase == PH_SKIP) st = ST_TRUNC;
            else begin
                st = ST_OK;
                dec = fr_rec_start - (fr_pos - fr_region);
                stray = fr_region - dec;
            end
            add_result(RK_STATUS, 0, 0, 1'b0, st, dec, stray, 1'b1);
            clear_frame();
        end
    endfunction

    // ---------------- result checking ----------------

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                want = expected_results.pop_front();
                check_field("result_kind", want.kind, m_axis_tuser);
                check_field("record_offset", want.offset, m_axis_tdata[10:0]);
                check_field("record_length", want.length, m_axis_tdata[22:11]);
                check_field("reportable", want.reportable, m_axis_tdata[23]);
                check_field("frame_status", want.status, m_axis_tdata[26:24]);
                check_field("decoded_length", want.decoded, m_axis_tdata[38:27]);
                check_field("stray_count", want.stray, m_axis_tdata[50:39]);
                check_field("last", want.last, m_axis_tlast);
            end
        end
    end

    // result side: random stall after each transfer while idling is on, long hold on request
    always begin : result_sink
        int gap;
        @(posedge aclk);
        if (hold_off_req) begin
            m_axis_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge aclk);
            m_axis_tready <= 1'b1;
            hold_off_req = 1'b0;
        end else if (m_axis_tvalid && m_axis_tready && idle_on) begin
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------- drivers ----------------

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= fin;
        do @(posedge aclk); while (!s_axis_tready);
        predict_byte(b, fin);
    endtask

    task automatic send_frame();
        foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic read_reg(input logic idx, input logic [7:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        check_field("prdata", {24'd0, want}, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (idx == REG_APDU_TAG) cfg_tag = val;
        else cfg_threshold = val;
        read_reg(idx, val);
    endtask

    // ---------------- frame builders ----------------

    function automatic bit known_tag(logic [7:0] b);
        return b == TY_STRUCT || b == TY_OCTETS || b == TY_U32 || b == TY_I16 ||
               b == TY_U16 || b == TY_I8 || b == TY_ENUM;
    endfunction

    function automatic void start_frame(logic [7:0] tag, int unsigned ext);
        frame_buf.delete();
        frame_buf.push_back(tag);
        repeat (4) frame_buf.push_back(rand_byte());
        frame_buf.push_back(ext[7:0]);
        repeat (ext) frame_buf.push_back(rand_byte());
        repeat (HDR_SIZE_LEN) frame_buf.push_back(rand_byte());
    endfunction

    // Append one top-level struct. The first record of a region carries the
    // fixed octet string of length 6. deep_to builds a chain of that many open
    // structs; with_junk puts an unknown type right after the count.
    function automatic void add_record(bit first, int deep_to, bit with_junk);
        int unsigned left [16];
        int unsigned c;
        int unsigned n;
        int unsigned pick;
        int          lvl;
        logic [7:0]  junk;
        frame_buf.push_back(TY_STRUCT);
        if (first) begin
            c = $urandom_range(1, 4);
            frame_buf.push_back(c[7:0]);
            frame_buf.push_back(TY_OCTETS);
            frame_buf.push_back(8'd6);
            repeat (6) frame_buf.push_back(rand_byte());
            left[0] = c - 1;
        end else begin
            c = (deep_to > 1 || with_junk) ? 1 : $urandom_range(0, 4);
            frame_buf.push_back(c[7:0]);
            left[0] = c;
        end
        if (with_junk) begin
            do junk = rand_byte(); while (known_tag(junk));
            frame_buf.push_back(junk);
            return;
        end
        lvl = 1;
        while (lvl > 0) begin
            if (left[lvl-1] == 0) begin
                lvl--;
                continue;
            end
            left[lvl-1]--;
            pick = (lvl < deep_to) ? 0 : $urandom_range(lvl < 5 ? 0 : 1, 7);
            case (pick)
                0: begin
                    c = (lvl < deep_to) ? 1 : $urandom_range(0, 3);
                    frame_buf.push_back(TY_STRUCT);
                    frame_buf.push_back(c[7:0]);
                    if (c != 0) begin
                        left[lvl] = c;
                        lvl++;
                    end
                end
                1: begin
                    n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 8);
                    frame_buf.push_back(TY_OCTETS);
                    frame_buf.push_back(n[7:0]);
                    repeat (n) frame_buf.push_back(rand_byte());
                end
                2: begin
                    frame_buf.push_back(TY_U32);
                    repeat (4) frame_buf.push_back(rand_byte());
                end
                3: begin
                    frame_buf.push_back(TY_I16);
                    repeat (2) frame_buf.push_back(rand_byte());
                end
                4: begin
                    frame_buf.push_back(TY_U16);
                    repeat (2) frame_buf.push_back(rand_byte());
                end
                5: begin
                    frame_buf.push_back(TY_I8);
                    frame_buf.push_back(rand_byte());
                end
                default: begin
                    frame_buf.push_back(TY_ENUM);
                    frame_buf.push_back(rand_byte());
                end
            endcase
        end
    endfunction

    function automatic void build_random_frame();
        int unsigned sel;
        int unsigned ext;
        int unsigned len;
        logic [7:0]  tag;
        sel = $urandom_range(0, 99);
        ext = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
        if (sel < 90) begin
            tag = cfg_tag;
            if (sel >= 85) tag = cfg_tag ^ 8'($urandom_range(1, 255));
            start_frame(tag, ext);
            add_record(1'b1, 0, 1'b0);
            repeat ($urandom_range(0, 4)) add_record(1'b0, 0, 1'b0);
            if (sel >= 65 && sel < 70) add_record(1'b0, STACK_DEPTH, 1'b0);
            else if (sel >= 70 && sel < 75) add_record(1'b0, STACK_DEPTH + 1, 1'b0);
            else if (sel >= 75 && sel < 80) add_record(1'b0, 0, 1'b1);
            if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 5))
                frame_buf.push_back(rand_byte());
            if (sel >= 80 && sel < 85) begin
                len = $urandom_range(1, frame_buf.size() - 1);
                while (frame_buf.size() > len) void'(frame_buf.pop_back());
            end
            // occasionally corrupt one byte anywhere
            if ($urandom_range(0, 19) == 0)
                frame_buf[$urandom_range(0, frame_buf.size() - 1)] = rand_byte();
        end else begin
            frame_buf.delete();
            len = (sel < 95) ? $urandom_range(1, 12) : $urandom_range(1, 40);
            repeat (len) frame_buf.push_back(rand_byte());
            if (sel < 95 || $urandom_range(0, 1) == 0) frame_buf[0] = cfg_tag;
        end
    endfunction

    // ---------------- tests ----------------

    task automatic test_register_reset();
        read_reg(REG_APDU_TAG, APDU_TAG_RST);
        read_reg(REG_THRESHOLD, THRESHOLD_RST);
    endtask

    task automatic test_short_and_bad_tag();
        frame_buf = '{cfg_tag, 8'h01, 8'h02};
        send_frame();
        frame_buf = '{cfg_tag ^ 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                      TY_STRUCT};
        send_frame();
    endtask

    task automatic test_cosem_start();
        start_frame(cfg_tag, 0);
        frame_buf.push_back(TY_STRUCT);
        frame_buf.push_back(8'h01);
        frame_buf.push_back(TY_U32);
        frame_buf.push_back(8'h06);
        send_frame();
    endtask

    task automatic test_all_types();
        start_frame(cfg_tag, 0);
        frame_buf = {frame_buf, TY_STRUCT, 8'h08,
                     TY_OCTETS, 8'h06, 8'h00, 8'hff, 8'h55, 8'haa, 8'h01, 8'h80,
                     TY_U32, 8'hff, 8'hff, 8'hff, 8'hff,
                     TY_I16, 8'h80, 8'h00,
                     TY_U16, 8'hff, 8'hff,
                     TY_I8, 8'h7f,
                     TY_ENUM, 8'h00,
                     TY_STRUCT, 8'h00,
                     TY_OCTETS, 8'h00,
                     8'h55};
        send_frame();
    endtask

    task automatic test_random_frames(input logic [7:0] tag, input logic [7:0] thr,
                                      input int unsigned quota, input bit idling);
        int unsigned sent;
        wait_drained();
        write_reg(REG_APDU_TAG, tag);
        write_reg(REG_THRESHOLD, thr);
        idle_on = idling;
        sent = 0;
        while (sent < quota) begin
            build_random_frame();
            sent += frame_buf.size();
            send_frame();
        end
    endtask

    // hold the result side while a frame full of short records keeps coming
    task automatic test_backpressure();
        wait_drained();
        idle_on = 1'b0;
        hold_off_req = 1'b1;
        start_frame(cfg_tag, 1);
        add_record(1'b1, 0, 1'b0);
        repeat (40) frame_buf = {frame_buf, TY_STRUCT, 8'h01, TY_ENUM, rand_byte()};
        send_frame();
        wait_drained();
        idle_on = 1'b1;
    endtask

    // one huge record, then stray bytes running past the frame capacity
    task automatic test_overlong_frame();
        start_frame(cfg_tag, 0);
        frame_buf = {frame_buf, TY_STRUCT, 8'h08, TY_OCTETS, 8'h06};
        repeat (6) frame_buf.push_back(rand_byte());
        repeat (7) begin
            frame_buf.push_back(TY_OCTETS);
            frame_buf.push_back(8'hff);
            repeat (255) frame_buf.push_back(rand_byte());
        end
        frame_buf.push_back(8'h55);
        while (frame_buf.size() < FRAME_CAP + 52) frame_buf.push_back(rand_byte());
        send_frame();
    endtask

    initial begin
        clear_frame();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_register_reset();
        test_short_and_bad_tag();
        test_cosem_start();
        test_all_types();
        test_random_frames(APDU_TAG_RST, THRESHOLD_RST, 250, 1'b1);
        test_random_frames(8'h00, 8'h00, 250, 1'b1);
        test_random_frames(8'hff, 8'hff, 250, 1'b0);
        test_backpressure();
        test_random_frames(rand_byte(), 8'($urandom_range(0, 40)), 250, 1'b1);
        test_random_frames(rand_byte(), 8'($urandom_range(0, 40)), 250, 1'b1);
        test_overlong_frame();
        wait_drained();
        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
